[hdl/tcpjq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the three-class priority job queue.
// No dependencies; every other file imports this package.
package tcpjq_pkg;

    // Storage sizing
    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;

    // Fixed field widths
    localparam int TAG_W    = 16;
    localparam int CLASS_W  = 2;
    localparam int STATUS_W = 2;
    localparam int BURST_W  = 8;

    localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE_BITS = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

    localparam logic [BURST_W-1:0] BURST_RESET = 8'd10;
    localparam logic [BURST_W-1:0] RUN_MAX     = 8'd255;

    // APB register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_BURST_LIMIT = 1'b0;   // word index, paddr[2]

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } t_opcode;

    typedef enum logic [CLASS_W-1:0] {
        CLS_CRIT = 2'd0,
        CLS_CTRL = 2'd1,
        CLS_BACK = 2'd2
    } t_class;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Queue status seen by the arbiter
    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

[hdl/tcpjq_ifs.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for job beats and result beats.
// Depends on tcpjq_pkg for field widths.
interface tcpjq_job_if;
    import tcpjq_pkg::*;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [CLASS_W-1:0] job_class;
    logic [TAG_W-1:0]   job_tag;

    modport source (output valid, output opcode, output job_class, output job_tag,
                    input ready);
    modport sink   (input valid, input opcode, input job_class, input job_tag,
                    output ready);
endinterface

interface tcpjq_res_if;
    import tcpjq_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [TAG_W-1:0]    popped_tag;
    logic [CLASS_W-1:0]  popped_class;

    modport source (output valid, output status, output popped_tag, output popped_class,
                    input ready);
    modport sink   (input valid, input status, input popped_tag, input popped_class,
                    output ready);
endinterface

[hdl/three_class_priority_job_queue_top.sv]
`timescale 1ns / 1ps
// Top level of the three-class priority job queue: job/result channels, APB register.
// Depends on tcpjq_pkg, tcpjq_ifs (channel interfaces) and tcpjq_fifo.
//
// Three FIFOs of job tags (critical, control, background) sit behind one job
// channel. A push beat stores its tag in the queue of its class (class 3 goes to
// background); a push to a full queue is dropped and reports status 1. A pop beat
// serves critical first, then background when control is empty or the run of
// back-to-back control pops has reached control_burst_limit (APB offset 0x0,
// reset 10, 0 means background always wins), otherwise control. A pop with all
// queues empty reports status 2. Every job beat yields exactly one result beat,
// in order. Throughput is one beat per clock while the result side keeps up: the
// beat lands in an input register, and the whole queue decision plus the head
// read and pointer update is done combinationally against the live queue state
// as the beat leaves that register, so back-to-back beats see each other's
// effect. The decision is then registered in the result register, which drives the result beat.
// The result register decouples the two sides: a new job is taken while a
// finished result still waits, and backpressure only stalls once both stages
// are full. The user must write the burst limit only while the block is idle (not enforced).
module three_class_priority_job_queue_top
    import tcpjq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tcpjq_job_if.sink             i_job,
    tcpjq_res_if.source           o_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ---------------- APB register ----------------
    logic [BURST_W-1:0] r_burst;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst <= BURST_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_BURST_LIMIT) begin
            r_burst <= pwdata[BURST_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_BURST_LIMIT) ? APB_DATA_W'(r_burst) : '0;

    // ---------------- stage 1: input register ----------------
    logic               r_in_valid;
    logic               r_in_op;
    logic [CLASS_W-1:0] r_in_cls;
    logic [TAG_W-1:0]   r_in_tag;

    logic               r_out_valid;
    logic               adv;      // stage 2 can take the held beat
    logic               fire;     // held beat is processed this cycle

    assign adv         = !r_out_valid || o_res.ready;
    assign fire        = r_in_valid && adv;
    assign i_job.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_job.valid && i_job.ready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job.valid && i_job.ready) begin
            r_in_op  <= i_job.opcode;
            r_in_cls <= i_job.job_class;
            r_in_tag <= i_job.job_tag;
        end
    end

    // ---------------- queues ----------------
    t_fifo_stat            stat  [3];
    logic [STORE_BITS-1:0] rdata [3];
    logic [2:0]            push_en;
    logic [2:0]            pop_en;

    for (genvar g = 0; g < 3; g++) begin : g_q
        tcpjq_fifo u_fifo (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_push  (push_en[g]),
            .i_pop   (pop_en[g]),
            .i_wdata (r_in_tag[STORE_BITS-1:0]),
            .o_rdata (rdata[g]),
            .o_stat  (stat[g])
        );
    end

    // ---------------- stage 2: decision ----------------
    logic [BURST_W-1:0] r_run, n_run;
    t_class             push_cls;
    t_class             pop_cls;
    logic               any_ready;
    t_status            n_status;
    logic [TAG_W-1:0]   n_tag;
    t_class             n_cls;

    // class 3 on a push is folded into background
    always_comb begin
        unique case (r_in_cls)
            CLS_CRIT: push_cls = CLS_CRIT;
            CLS_CTRL: push_cls = CLS_CTRL;
            default:  push_cls = CLS_BACK;
        endcase
    end

    // strict priority with the control burst limit
    always_comb begin
        any_ready = 1'b1;
        priority if (!stat[CLS_CRIT].empty) begin
            pop_cls = CLS_CRIT;
        end else if (!stat[CLS_BACK].empty && (stat[CLS_CTRL].empty || r_run >= r_burst)) begin
            pop_cls = CLS_BACK;
        end else if (!stat[CLS_CTRL].empty) begin
            pop_cls = CLS_CTRL;
        end else begin
            pop_cls   = CLS_CRIT;
            any_ready = 1'b0;
        end
    end

    always_comb begin
        push_en  = '0;
        pop_en   = '0;
        n_run    = r_run;
        n_status = ST_OK;
        n_tag    = '0;
        n_cls    = CLS_CRIT;
        if (r_in_op == OP_PUSH) begin
            if (stat[push_cls].full) begin
                n_status = ST_FULL;
            end else begin
                push_en[push_cls] = fire;
            end
        end else if (!any_ready) begin
            n_status = ST_EMPTY;
        end else begin
            pop_en[pop_cls] = fire;
            n_tag           = TAG_W'(rdata[pop_cls]);
            n_cls           = pop_cls;
            if (pop_cls == CLS_CTRL) begin
                if (r_run != RUN_MAX) begin
                    n_run = r_run + 1'b1;
                end
            end else begin
                n_run = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= '0;
        end else if (fire) begin
            r_run <= n_run;
        end
    end

    // ---------------- result register ----------------
    logic [STATUS_W-1:0] r_out_status;
    logic [TAG_W-1:0]    r_out_tag;
    logic [CLASS_W-1:0]  r_out_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_status <= n_status;
            r_out_tag    <= n_tag;
            r_out_cls    <= n_cls;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_status;
    assign o_res.popped_tag   = r_out_tag;
    assign o_res.popped_class = r_out_cls;

    // ---------------- checks ----------------
    // A waiting critical tag always wins a pop
    a_crit_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_op == OP_POP && !stat[CLS_CRIT].empty)
        |=> (r_out_status == ST_OK && r_out_cls == CLS_CRIT))
        else $error("critical tag bypassed");

    // Any non-control pop restarts the control run
    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_op == OP_POP && any_ready && pop_cls != CLS_CTRL) |=> (r_run == '0))
        else $error("control run not cleared");

    // Empty and push results carry no tag or class
    a_no_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && !(r_in_op == OP_POP && any_ready))
        |=> (r_out_tag == '0 && r_out_cls == CLS_CRIT))
        else $error("stray tag on non-pop result");

endmodule

[hdl/tcpjq_fifo.sv]
`timescale 1ns / 1ps
// One tag FIFO: flop storage, head/tail pointers and fill count.
// Depends on tcpjq_pkg. Push and pop are never asserted together.
module tcpjq_fifo
    import tcpjq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_pop,
    input  logic [STORE_BITS-1:0] i_wdata,
    output logic [STORE_BITS-1:0] o_rdata,
    output t_fifo_stat            o_stat
);

    logic [STORE_BITS-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   r_head, n_head;
    logic [PTR_BITS-1:0]   r_tail, n_tail;
    logic [CNT_BITS-1:0]   r_count, n_count;

    function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
        logic [PTR_BITS-1:0] q;
        if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_push) begin
            n_tail  = ptr_inc(r_tail);
            n_count = r_count + 1'b1;
        end else if (i_pop) begin
            n_head  = ptr_inc(r_head);
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_wdata;
        end
    end

    assign o_rdata      = r_mem[r_head];
    assign o_stat.full  = (r_count == CNT_BITS'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    // Arbiter must never overfill or underflow a queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_stat.full))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_stat.empty))
        else $error("pop from empty queue");

    // Pointers and count stay coherent: equal pointers mean empty or full
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == r_tail) |-> (o_stat.empty || o_stat.full))
        else $error("pointer/count mismatch");

endmodule

[dv/three_class_priority_job_queue_top_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for three_class_priority_job_queue_top: random push/pop beats,
// a shadow queue model in a scoreboard class, and APB writes of the burst limit.
// Depends on tcpjq_pkg, tcpjq_ifs and the top level under hdl/.

typedef struct {
    tcpjq_pkg::t_status status;
    logic [tcpjq_pkg::TAG_W-1:0] tag;
    tcpjq_pkg::t_class cls;
} t_job_result;

// Shadow copy of the three queues; predicts the result of every accepted job beat.
class t_job_scoreboard;
    logic [tcpjq_pkg::TAG_W-1:0] slots [3][tcpjq_pkg::QUEUE_DEPTH];
    int unsigned head [3];
    int unsigned fill [3];
    logic [tcpjq_pkg::BURST_W-1:0] run_len;
    logic [tcpjq_pkg::BURST_W-1:0] burst_limit;
    t_job_result awaited_q [$];
    int unsigned errors;
    int unsigned beats;
    int unsigned drops;
    int unsigned empties;
    int unsigned served [3];

    function new();
        for (int i = 0; i < 3; i++) begin
            head[i] = 0;
            fill[i] = 0;
            served[i] = 0;
        end
        run_len = '0;
        burst_limit = tcpjq_pkg::BURST_RESET;
        errors = 0;
        beats = 0;
        drops = 0;
        empties = 0;
    endfunction

    task report(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    function int unsigned pending();
        return awaited_q.size();
    endfunction

    function int unsigned queued();
        return fill[0] + fill[1] + fill[2];
    endfunction

    // Accepted job beat: update the shadow queues and queue the expected result.
    function void note_job(logic op, logic [tcpjq_pkg::CLASS_W-1:0] cls,
                           logic [tcpjq_pkg::TAG_W-1:0] tag);
        t_job_result r;
        tcpjq_pkg::t_class c;
        r.status = tcpjq_pkg::ST_OK;
        r.tag = '0;
        r.cls = tcpjq_pkg::CLS_CRIT;
        beats++;
        if (op == tcpjq_pkg::OP_PUSH) begin
            // the unused class code lands in background
            c = (cls > tcpjq_pkg::CLS_BACK) ? tcpjq_pkg::CLS_BACK : tcpjq_pkg::t_class'(cls);
            if (fill[c] >= tcpjq_pkg::QUEUE_DEPTH) begin
                r.status = tcpjq_pkg::ST_FULL;
                drops++;
            end else begin
                slots[c][(head[c] + fill[c]) % tcpjq_pkg::QUEUE_DEPTH] = tag;
                fill[c]++;
            end
        end else begin
            if (fill[tcpjq_pkg::CLS_CRIT] != 0)
                c = tcpjq_pkg::CLS_CRIT;
            else if (fill[tcpjq_pkg::CLS_BACK] != 0 &&
                     (fill[tcpjq_pkg::CLS_CTRL] == 0 || run_len >= burst_limit))
                c = tcpjq_pkg::CLS_BACK;
            else if (fill[tcpjq_pkg::CLS_CTRL] != 0)
                c = tcpjq_pkg::CLS_CTRL;
            else
                r.status = tcpjq_pkg::ST_EMPTY;
            if (r.status == tcpjq_pkg::ST_OK) begin
                r.tag = slots[c][head[c]];
                r.cls = c;
                head[c] = (head[c] + 1) % tcpjq_pkg::QUEUE_DEPTH;
                fill[c]--;
                served[c]++;
                if (c == tcpjq_pkg::CLS_CTRL) begin
                    if (run_len < tcpjq_pkg::RUN_MAX)
                        run_len++;
                end else begin
                    run_len = '0;
                end
            end else begin
                empties++;
            end
        end
        awaited_q.insert(awaited_q.size(), r);
    endfunction

    task check_result(logic [tcpjq_pkg::STATUS_W-1:0] status,
                      logic [tcpjq_pkg::TAG_W-1:0] tag,
                      logic [tcpjq_pkg::CLASS_W-1:0] cls);
        t_job_result e;
        if (awaited_q.size() == 0) begin
            report($sformatf("result beat with nothing awaited (status %0d tag %h)",
                             status, tag));
        end else begin
            e = awaited_q[0];
            awaited_q.delete(0);
            if (status !== e.status)
                report($sformatf("status %0d, expected %0d", status, e.status));
            if (tag !== e.tag)
                report($sformatf("popped_tag %h, expected %h", tag, e.tag));
            if (cls !== e.cls)
                report($sformatf("popped_class %0d, expected %0d", cls, e.cls));
        end
    endtask
endclass

module three_class_priority_job_queue_top_tb;
    import tcpjq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MIX_BEATS   = 260;
    localparam int IDLE_PCT    = 31;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;

    // no idling on either side while set
    logic calm;
    int unsigned cycle_count;
    int unsigned settings_run;

    tcpjq_job_if job_if ();
    tcpjq_res_if res_if ();

    t_job_scoreboard sb;

    three_class_priority_job_queue_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (job_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a stuck handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("FAIL");
            $finish;
        end
    end

    // Result-side backpressure, changed on the falling edge.
    always @(negedge i_clk) begin
        res_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Monitor: results are checked before the job beat of the same edge is noted,
    // since a job never yields its result in the edge it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready)
                sb.check_result(res_if.status, res_if.popped_tag, res_if.popped_class);
            if (job_if.valid && job_if.ready)
                sb.note_job(job_if.opcode, job_if.job_class, job_if.job_tag);
        end
    end

    // Entered and left at a falling edge; holds valid until the beat is taken.
    task automatic send_job(input logic op, input logic [CLASS_W-1:0] cls,
                            input logic [TAG_W-1:0] tag);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            job_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        job_if.valid     <= 1'b1;
        job_if.opcode    <= op;
        job_if.job_class <= cls;
        job_if.job_tag   <= tag;
        @(posedge i_clk);
        while (!job_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_pop();
        send_job(OP_POP, CLASS_W'($urandom()), TAG_W'($urandom()));
    endtask

    // Class mix leans on control so runs reach the burst limit.
    function automatic logic [CLASS_W-1:0] pick_class();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 20) return CLS_CRIT;
        if (r < 60) return CLS_CTRL;
        if (r < 88) return CLS_BACK;
        return '1;
    endfunction

    // Every job beat makes a result, so idle means nothing awaited.
    task automatic wait_idle();
        job_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // APB write of the burst limit with junk in the upper bits, then read back.
    task automatic write_burst_limit(input logic [BURST_W-1:0] limit);
        logic [APB_DATA_W-1:0] word;
        logic [APB_DATA_W-1:0] rd;
        word = $urandom();
        word[BURST_W-1:0] = limit;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_BURST_LIMIT, 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.burst_limit = limit;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[BURST_W-1:0] !== limit)
            sb.report($sformatf("burst limit reads %h, wrote %h", rd[BURST_W-1:0], limit));
        settings_run++;
    endtask

    // Random push/pop traffic; push share drifts so queues swing between full and empty.
    task automatic random_mix(input int unsigned n);
        int unsigned push_pct;
        push_pct = 50;
        for (int i = 0; i < n; i++) begin
            if (i % 40 == 0) push_pct = $urandom_range(30, 75);
            if ($urandom_range(99) < push_pct)
                send_job(OP_PUSH, pick_class(), TAG_W'($urandom()));
            else
                send_pop();
        end
    endtask

    // Over 255 control pops in a row with background absent: the run count must
    // saturate, not wrap, so a late background job still wins at limit 255.
    task automatic control_marathon();
        int unsigned n;
        n = sb.queued();
        for (int i = 0; i < n; i++) send_pop();
        for (int i = 0; i < 260; i++) begin
            send_job(OP_PUSH, CLS_CTRL, TAG_W'($urandom()));
            send_pop();
        end
        send_job(OP_PUSH, CLS_BACK, TAG_W'($urandom()));
        send_job(OP_PUSH, CLS_CTRL, TAG_W'($urandom()));
        send_pop();
        send_pop();
    endtask

    initial begin
        logic [BURST_W-1:0] limits [6];
        sb = new();
        cycle_count      = 0;
        settings_run     = 1;
        calm             = 1'b0;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        job_if.valid     = 1'b0;
        job_if.opcode    = OP_PUSH;
        job_if.job_class = CLS_CRIT;
        job_if.job_tag   = '0;
        res_if.ready     = 1'b0;
        limits = '{BURST_RESET, 8'd0, 8'd1, 8'd3, RUN_MAX,
                   BURST_W'($urandom_range(4, 254))};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty pop, tag extremes, class code three, then a full-queue drop.
        send_job(OP_POP, '1, '1);
        send_job(OP_PUSH, CLS_CRIT, '0);
        send_job(OP_PUSH, CLS_CTRL, '1);
        send_job(OP_PUSH, '1, 16'h1234);
        send_job(OP_PUSH, CLS_BACK, 16'hA5A5);
        repeat (4) send_pop();
        send_pop();
        for (int i = 0; i <= QUEUE_DEPTH; i++)
            send_job(OP_PUSH, CLS_CRIT, TAG_W'(16'hC000 + i));

        // One phase per burst limit; the first runs at the reset value.
        for (int p = 0; p < 6; p++) begin
            if (p != 0) begin
                wait_idle();
                write_burst_limit(limits[p]);
            end
            calm = (p == 2);
            if (limits[p] == RUN_MAX) control_marathon();
            random_mix(MIX_BEATS);
        end
        calm = 1'b0;

        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("ran %0d job beats over %0d burst-limit settings in %0d cycles",
                 sb.beats, settings_run, cycle_count);
        $display("served crit/ctrl/back %0d/%0d/%0d, %0d full drops, %0d empty pops",
                 sb.served[CLS_CRIT], sb.served[CLS_CTRL], sb.served[CLS_BACK],
                 sb.drops, sb.empties);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/tcpjq_pkg.sv
hdl/tcpjq_ifs.sv
hdl/tcpjq_fifo.sv
hdl/three_class_priority_job_queue_top.sv
dv/three_class_priority_job_queue_top_tb.sv
